/* hw/rtl/trie_word_store_unit_macros.svh */
// assertion macros for the trie word store
`ifndef TRIE_WORD_STORE_UNIT_MACROS_SVH
`define TRIE_WORD_STORE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// condition must hold at every edge outside reset
`define TWS_ASSERT_ALWAYS(lbl, clk, rst, expr) \
lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
   else $error("invariant violated");
// same-cycle implication
`define TWS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("implication violated");
// next-cycle implication
`define TWS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("next-cycle implication violated");
`else
`define TWS_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define TWS_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define TWS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/tws_pkg.sv */
`default_nettype none
package tws_pkg;

   localparam int NODE_COUNT    = 256;
   localparam int ALPHABET_SIZE = 256;
   localparam int SYM_W         = 8;
   localparam int NODE_W        = $clog2(NODE_COUNT);
   localparam int SYM_IDX_W     = $clog2(ALPHABET_SIZE);
   localparam int TABLE_ADDR_W  = NODE_W + SYM_IDX_W;
   // table is addressed by {node, symbol}, so it spans the whole address space
   localparam int TABLE_DEPTH   = 2 ** TABLE_ADDR_W;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_PREFIX = 2'd2,
      CMD_RSVD   = 2'd3
   } cmd_type;

   // one access to the child table
   typedef struct packed {
      logic                    rd_en;
      logic                    wr_en;
      logic [TABLE_ADDR_W-1:0] addr;
      logic [NODE_W-1:0]       wdata;
   } tbl_req_type;

endpackage
`default_nettype wire

/* hw/rtl/tws_child_store.sv */
`default_nettype none
module tws_child_store (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire tws_pkg::tbl_req_type      tbl_req,
   output logic [tws_pkg::NODE_W-1:0]     rd_data,
   output logic                           clear_done
);

   logic [tws_pkg::NODE_W-1:0]       child_mem_ff [tws_pkg::TABLE_DEPTH];
   logic [tws_pkg::NODE_W-1:0]       rd_data_ff;
   logic [tws_pkg::TABLE_ADDR_W-1:0] clr_addr_ff;
   logic [tws_pkg::TABLE_ADDR_W-1:0] clr_addr_in;
   logic                             clearing_ff;
   logic                             clearing_in;
   logic                             we;
   logic [tws_pkg::TABLE_ADDR_W-1:0] waddr;
   logic [tws_pkg::NODE_W-1:0]       wdata;

   // sweep of zeros over the whole table after reset
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (&clr_addr_ff) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clearing_ff <= clearing_in;
      end
   end

   assign we    = clearing_ff | tbl_req.wr_en;
   assign waddr = clearing_ff ? clr_addr_ff : tbl_req.addr;
   assign wdata = clearing_ff ? '0 : tbl_req.wdata;

   always_ff @(posedge clock) begin
      if (we) begin
         child_mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_req.rd_en) begin
         rd_data_ff <= child_mem_ff[tbl_req.addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_done = ~clearing_ff;

endmodule
`default_nettype wire

/* hw/rtl/trie_word_store_unit.sv */
`default_nettype none
// channel  | dir | beat contents
// req      | in  | tdata[7:0] symbol, tuser[1:0] command, tlast last byte of word
// rsp      | out | tdata[0] found, tdata[1] pool_full, tdata[7:2] zero
//
// a byte beat reads the child table in ST_IDLE, then uses the child in ST_WALK
// the last byte of a word then goes on to ST_FINISH, which builds the response beat
// the child table read feeds the next byte's address, so a byte is not taken before the last one is through
// a byte after a miss skips the table read and ST_WALK, going to ST_FINISH when it ends the word
// after reset the child table's 65536 entries are swept to zero, req_tready low
// a pending response holds the finishing step, and req_tready stays low meanwhile
`include "trie_word_store_unit_macros.svh"
module trie_word_store_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] symbol
   input  wire logic [1:0] req_tuser,   // [1:0] command
   input  wire logic       req_tlast,   // last byte of the word
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [0] found, [1] pool_full, [7:2] zero
);

   // control sequencer, one-hot
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   localparam logic [tws_pkg::NODE_W:0] POOL_LIMIT = (tws_pkg::NODE_W + 1)'(tws_pkg::NODE_COUNT);
   localparam logic [tws_pkg::SYM_W:0]  SYM_LIMIT  = (tws_pkg::SYM_W + 1)'(tws_pkg::ALPHABET_SIZE);

   state_type                         state_ff, state_in;
   logic [tws_pkg::NODE_W-1:0]        cursor_ff, cursor_in;
   logic [tws_pkg::NODE_W:0]          next_free_ff, next_free_in;
   logic                              missed_ff, missed_in;
   logic                              ran_out_ff, ran_out_in;
   tws_pkg::cmd_type                  cmd_ff, cmd_in;
   logic                              last_ff, last_in;
   logic [tws_pkg::TABLE_ADDR_W-1:0]  addr_ff, addr_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              found_ff, found_in;
   logic                              full_ff, full_in;

   // end-of-word marks, one per node; a node's mark is written when it is allocated
   logic                              mark_mem_ff [tws_pkg::NODE_COUNT];
   logic                              mark_rd_ff;
   logic                              mark_rd_en;
   logic [tws_pkg::NODE_W-1:0]        mark_raddr;
   logic                              mark_we;
   logic [tws_pkg::NODE_W-1:0]        mark_waddr;
   logic                              mark_wdata;

   tws_pkg::tbl_req_type              tbl_req;
   logic [tws_pkg::NODE_W-1:0]        tbl_rd_data;
   logic                              clear_done;
   logic                              req_fire;
   tws_pkg::cmd_type                  req_cmd;
   logic                              sym_out;
   logic [tws_pkg::NODE_W:0]          cursor_ext;

   tws_child_store u_child_store (
      .clock      (clock),
      .reset      (reset),
      .tbl_req    (tbl_req),
      .rd_data    (tbl_rd_data),
      .clear_done (clear_done)
   );

   assign req_tready = clear_done & (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign req_cmd    = tws_pkg::cmd_type'(req_tuser);
   // a symbol beyond the alphabet is a miss for every command
   assign sym_out    = {1'b0, req_tdata} >= SYM_LIMIT;
   assign cursor_ext = {1'b0, cursor_ff};

   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      next_free_in = next_free_ff;
      missed_in    = missed_ff;
      ran_out_in   = ran_out_ff;
      cmd_in       = cmd_ff;
      last_in      = last_ff;
      addr_in      = addr_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      tbl_req      = '0;
      mark_we      = 1'b0;
      mark_waddr   = cursor_ff;
      mark_wdata   = 1'b0;
      mark_rd_en   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_cmd != tws_pkg::CMD_RSVD) begin
               cmd_in  = req_cmd;
               last_in = req_tlast;
               if (missed_ff || sym_out) begin
                  // word already lost: the byte only counts toward the end
                  missed_in = 1'b1;
                  if (req_tlast) begin
                     state_in = ST_FINISH;
                  end
               end else begin
                  tbl_req.rd_en = 1'b1;
                  tbl_req.addr  = {cursor_ff, req_tdata[tws_pkg::SYM_IDX_W-1:0]};
                  addr_in       = tbl_req.addr;
                  state_in      = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // child table data for addr_ff is valid here; the write below is the
            // only access this cycle, so read and write never collide
            if (tbl_rd_data != '0) begin
               cursor_in = tbl_rd_data;
            end else if (cmd_ff != tws_pkg::CMD_INSERT) begin
               missed_in = 1'b1;
            end else if (next_free_ff >= POOL_LIMIT) begin
               missed_in  = 1'b1;
               ran_out_in = 1'b1;
            end else begin
               tbl_req.wr_en = 1'b1;
               tbl_req.addr  = addr_ff;
               tbl_req.wdata = next_free_ff[tws_pkg::NODE_W-1:0];
               cursor_in     = next_free_ff[tws_pkg::NODE_W-1:0];
               next_free_in  = next_free_ff + 1'b1;
               // fresh node starts without an end mark
               mark_we       = 1'b1;
               mark_waddr    = next_free_ff[tws_pkg::NODE_W-1:0];
               mark_wdata    = 1'b0;
            end
            // fetch the end mark of the node reached, used by a search result
            mark_rd_en = 1'b1;
            state_in   = last_ff ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               found_in = 1'b0;
               full_in  = 1'b0;
               case (cmd_ff)
                  tws_pkg::CMD_INSERT: begin
                     if (!missed_ff) begin
                        found_in   = 1'b1;
                        mark_we    = 1'b1;
                        mark_waddr = cursor_ff;
                        mark_wdata = 1'b1;
                     end else begin
                        full_in = ran_out_ff;
                     end
                  end
                  tws_pkg::CMD_SEARCH: found_in = ~missed_ff & mark_rd_ff;
                  default:             found_in = ~missed_ff;
               endcase
               rsp_valid_in = 1'b1;
               cursor_in    = '0;
               missed_in    = 1'b0;
               ran_out_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      mark_raddr = cursor_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         next_free_ff <= (tws_pkg::NODE_W + 1)'(1);
         missed_ff    <= 1'b0;
         ran_out_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         next_free_ff <= next_free_in;
         missed_ff    <= missed_in;
         ran_out_ff   <= ran_out_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // beat payload and result registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      last_ff  <= last_in;
      addr_ff  <= addr_in;
      found_ff <= found_in;
      full_ff  <= full_in;
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem_ff[mark_waddr] <= mark_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mark_rd_en) begin
         mark_rd_ff <= mark_mem_ff[mark_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, full_ff, found_ff};

   `TWS_ASSERT_ALWAYS(a_pool_bound, clock, reset, next_free_ff <= POOL_LIMIT)
   `TWS_ASSERT_ALWAYS(a_cursor_allocated, clock, reset, cursor_ext < next_free_ff)
   `TWS_ASSERT_IMPLY(a_no_accept_while_clearing, clock, reset, req_tready, clear_done)
   `TWS_ASSERT_NEXT(a_alloc_step, clock, reset, tbl_req.wr_en, next_free_ff == $past(next_free_ff) + 1'b1)
   `TWS_ASSERT_IMPLY(a_full_not_found, clock, reset, rsp_valid_ff, !(found_ff && full_ff))

endmodule
`default_nettype wire

/* test/trie_word_store_unit_tb.sv */
`default_nettype none
module trie_word_store_unit_tb;

   localparam int WATCHDOG_LIMIT = 300000;  // the limit covers the clearing sweep of all 65536 table entries
   localparam int WORD_ITEMS     = 1850;
   localparam int SPELL_MAX      = 12;
   localparam int LEXICON_SIZE   = 32;
   localparam int HOLD_CYCLES    = 600;

   typedef struct packed {
      tws_pkg::cmd_type cmd;
      logic [7:0]       sym;
      logic             last;
   } byte_beat_type;

   // same layout as rsp_tdata
   typedef struct packed {
      logic [5:0] pad;
      logic       pool_full;
      logic       found;
   } word_result_type;

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'd0;  // [7:0] symbol
   logic [1:0] req_tuser  = 2'd0;  // [1:0] command
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // [0] found, [1] pool_full, [7:2] zero

   trie_word_store_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // trie mirror
   bit [tws_pkg::NODE_W-1:0] child_of [tws_pkg::TABLE_DEPTH];
   bit                       word_end_mark [tws_pkg::NODE_COUNT];
   int                       next_free_node = 1;
   bit [tws_pkg::NODE_W-1:0] cursor_node    = '0;
   bit                       word_missed    = 1'b0;
   bit                       pool_ran_out   = 1'b0;

   byte_beat_type   pending_beats [$];
   word_result_type expected_results [$];
   int              mismatch_count = 0;
   int              real_beats     = 0;

   logic [7:0] spelling [SPELL_MAX];
   logic [7:0] lexicon [LEXICON_SIZE][SPELL_MAX];
   int         lexicon_len [LEXICON_SIZE];
   int         lexicon_n = 0;

   function automatic void walk_trie(byte_beat_type b);
      logic [tws_pkg::TABLE_ADDR_W-1:0] slot;
      bit [tws_pkg::NODE_W-1:0]         kid;
      word_result_type                  res;
      if (b.cmd == tws_pkg::CMD_RSVD) return;
      if (!word_missed) begin
         if (int'(b.sym) >= tws_pkg::ALPHABET_SIZE) begin
            word_missed = 1'b1;
         end else begin
            slot = {cursor_node, b.sym[tws_pkg::SYM_IDX_W-1:0]};
            kid  = child_of[slot];
            if (kid != 0) begin
               cursor_node = kid;
            end else if (b.cmd != tws_pkg::CMD_INSERT) begin
               word_missed = 1'b1;
            end else if (next_free_node >= tws_pkg::NODE_COUNT) begin
               word_missed  = 1'b1;
               pool_ran_out = 1'b1;
            end else begin
               child_of[slot] = next_free_node[tws_pkg::NODE_W-1:0];
               cursor_node    = next_free_node[tws_pkg::NODE_W-1:0];
               next_free_node++;
            end
         end
      end
      if (!b.last) return;
      res = '0;
      case (b.cmd)
         tws_pkg::CMD_INSERT: begin
            if (!word_missed) begin
               word_end_mark[cursor_node] = 1'b1;
               res.found = 1'b1;
            end else begin
               res.pool_full = pool_ran_out;
            end
         end
         tws_pkg::CMD_SEARCH: res.found = !word_missed && word_end_mark[cursor_node];
         default:             res.found = !word_missed;
      endcase
      expected_results.push_back(res);
      cursor_node  = '0;
      word_missed  = 1'b0;
      pool_ran_out = 1'b0;
   endfunction

   function automatic void push_beat(tws_pkg::cmd_type c, logic [7:0] s, logic l);
      byte_beat_type b;
      b.cmd  = c;
      b.sym  = s;
      b.last = l;
      pending_beats.push_back(b);
      if (c != tws_pkg::CMD_RSVD) real_beats++;
   endfunction

   // queue the first n bytes of spelling as one word
   function automatic void queue_word(tws_pkg::cmd_type c, int n, bit jumble, bit noisy);
      tws_pkg::cmd_type bc;
      for (int i = 0; i < n; i++) begin
         if (noisy && $urandom_range(0, 19) == 0)
            push_beat(tws_pkg::CMD_RSVD, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
         bc = c;
         if (jumble && i < n - 1) bc = tws_pkg::cmd_type'($urandom_range(0, 2));
         push_beat(bc, spelling[i], i == n - 1);
      end
   endfunction

   // mostly a few letters so that words share paths
   function automatic logic [7:0] pick_symbol();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 8'h61 + 8'($urandom_range(0, 3));
      if (r == 7) return $urandom_range(0, 1) ? 8'h00 : 8'hff;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void remember_word(int n);
      int k;
      if (lexicon_n < LEXICON_SIZE) begin
         k = lexicon_n;
         lexicon_n++;
      end else begin
         k = $urandom_range(0, LEXICON_SIZE - 1);
      end
      for (int i = 0; i < n; i++) lexicon[k][i] = spelling[i];
      lexicon_len[k] = n;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: %s got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // driver: bursts of beats with random gaps between them
   byte_beat_type cur_beat;
   int            burst_left = 1;
   int            gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) walk_trie(cur_beat);
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            cur_beat = pending_beats.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= cur_beat.sym;
            req_tuser  <= cur_beat.cmd;
            req_tlast  <= cur_beat.last;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 48);
               gap_left   = $urandom_range(1, 9);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: changing stall modes, plus one long hold-off
   int stall_mode   = 0;
   int mode_left    = 0;
   int hold_left    = 0;
   int seen_results = 0;
   bit hold_done    = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) seen_results++;
         if (!hold_done && seen_results == 100) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(10, 150);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // monitor
   word_result_type got_result;
   word_result_type want_result;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_result = rsp_tdata;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, tdata", rsp_tdata, 0);
         end else begin
            want_result = expected_results.pop_front();
            if (got_result.found !== want_result.found)
               report_mismatch("found", got_result.found, want_result.found);
            if (got_result.pool_full !== want_result.pool_full)
               report_mismatch("pool_full", got_result.pool_full, want_result.pool_full);
            if (got_result.pad !== 6'd0)
               report_mismatch("tdata pad", got_result.pad, 0);
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int r;
      int k;
      int n;
      tws_pkg::cmd_type c;
      bit jumble;

      // directed words
      spelling[0] = 8'h61;
      spelling[1] = 8'h62;
      spelling[2] = 8'h63;
      queue_word(tws_pkg::CMD_INSERT, 2, 0, 0);
      queue_word(tws_pkg::CMD_SEARCH, 2, 0, 0);
      queue_word(tws_pkg::CMD_SEARCH, 1, 0, 0);   // path only, no word ends there
      queue_word(tws_pkg::CMD_PREFIX, 1, 0, 0);
      queue_word(tws_pkg::CMD_PREFIX, 3, 0, 0);   // misses on the third byte
      spelling[0] = 8'h00;
      queue_word(tws_pkg::CMD_INSERT, 1, 0, 0);
      spelling[0] = 8'hff;
      queue_word(tws_pkg::CMD_INSERT, 1, 0, 0);
      queue_word(tws_pkg::CMD_SEARCH, 1, 0, 0);
      spelling[1] = 8'h00;
      queue_word(tws_pkg::CMD_PREFIX, 2, 0, 0);
      // reserved beats inside a word are dropped, last mark included
      push_beat(tws_pkg::CMD_SEARCH, 8'h61, 1'b0);
      push_beat(tws_pkg::CMD_RSVD, 8'h5a, 1'b1);
      push_beat(tws_pkg::CMD_RSVD, 8'ha5, 1'b0);
      push_beat(tws_pkg::CMD_SEARCH, 8'h62, 1'b1);
      // mixed commands: result follows the last byte
      push_beat(tws_pkg::CMD_INSERT, 8'h78, 1'b0);
      push_beat(tws_pkg::CMD_SEARCH, 8'h79, 1'b1);
      push_beat(tws_pkg::CMD_SEARCH, 8'h7a, 1'b0);
      push_beat(tws_pkg::CMD_INSERT, 8'h77, 1'b1);   // miss is not a full pool
      push_beat(tws_pkg::CMD_SEARCH, 8'h61, 1'b0);
      push_beat(tws_pkg::CMD_INSERT, 8'h62, 1'b1);

      // random words, mostly built from words already stored
      while (real_beats < WORD_ITEMS) begin
         r      = $urandom_range(0, 99);
         c      = tws_pkg::CMD_SEARCH;
         jumble = 1'b0;
         if (r < 30 || lexicon_n == 0) begin
            c = tws_pkg::CMD_INSERT;
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) spelling[i] = pick_symbol();
            remember_word(n);
         end else if (r < 38) begin
            // long words of any bytes drain the pool
            c = tws_pkg::CMD_INSERT;
            n = $urandom_range(6, 10);
            for (int i = 0; i < n; i++) spelling[i] = 8'($urandom_range(0, 255));
            remember_word(n);
         end else begin
            k = $urandom_range(0, lexicon_n - 1);
            n = lexicon_len[k];
            for (int i = 0; i < n; i++) spelling[i] = lexicon[k][i];
            if (r < 52) begin
               if ($urandom_range(0, 4) == 0)
                  spelling[$urandom_range(0, n - 1)] = pick_symbol();
            end else if (r < 60) begin
               n = $urandom_range(1, n);
            end else if (r < 66) begin
               if (n < SPELL_MAX) begin
                  spelling[n] = pick_symbol();
                  n++;
               end
            end else if (r < 80) begin
               c = tws_pkg::CMD_PREFIX;
               n = $urandom_range(1, n);
            end else if (r < 88) begin
               c = tws_pkg::CMD_INSERT;
            end else begin
               c      = tws_pkg::cmd_type'($urandom_range(0, 2));
               jumble = 1'b1;
            end
         end
         queue_word(c, n, jumble, 1'b1);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* sim.f */
+incdir+hw/rtl
hw/rtl/tws_pkg.sv
hw/rtl/tws_child_store.sv
hw/rtl/trie_word_store_unit.sv
test/trie_word_store_unit_tb.sv
